// ----- rtl/core/gpdht_pkg.sv -----
// Package with shared types and constants for the GPIO pin bank with sensor responder.
`default_nettype none
package gpdht_pkg;

    // Item functions.
    typedef enum logic [2:0] {
        FUNC_MODE  = 3'd0,
        FUNC_WRITE = 3'd1,
        FUNC_READ  = 3'd2,
        FUNC_DRIVE = 3'd3,
        FUNC_LOAD  = 3'd4
    } t_func;

    // Mode codes.
    localparam logic [2:0] MODE_INPUT    = 3'd1;
    localparam logic [2:0] MODE_PULLUP   = 3'd2;
    localparam logic [2:0] MODE_PULLDOWN = 3'd3;
    localparam logic [2:0] MODE_OUTPUT   = 3'd4;

    // Stored level codes.
    localparam logic [1:0] LVL_LOW     = 2'd0;
    localparam logic [1:0] LVL_HIGH    = 2'd1;
    localparam logic [1:0] LVL_UNKNOWN = 2'd2;

    // Reply timing in microseconds.
    localparam logic [31:0] T_PRE_HIGH1 = 32'd40;
    localparam logic [31:0] T_PRE_LOW   = 32'd120;
    localparam logic [31:0] T_PRE_HIGH2 = 32'd200;
    localparam logic [31:0] T_BIT_LOW   = 32'd50;
    localparam logic [31:0] T_HIGH_ZERO = 32'd27;
    localparam logic [31:0] T_HIGH_ONE  = 32'd70;
    localparam int          REPLY_BITS  = 40;
    localparam logic [15:0] CFG_RESET   = 16'd800;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Per-pin record held in the state memory.
    typedef struct packed {
        logic [1:0]  level;
        logic [2:0]  mode;
        logic        sens;
        logic        busy;
        logic [15:0] temp;
        logic [15:0] hum;
        logic [31:0] low_start;
        logic [31:0] trig;
    } t_pin_rec;

    // Request into the reply bit scanner.
    typedef struct packed {
        logic        start;
        logic [31:0] elapsed;
        logic [39:0] bits;
    } t_scan_req;

    // Scanner answer.
    typedef struct packed {
        logic done;
        logic level;
        logic finished;
    } t_scan_rsp;

endpackage
`default_nettype wire

// ----- rtl/core/gpdht_mem.sv -----
// Per-pin state memory with one write port and one registered read port.
`default_nettype none
module gpdht_mem #(
    parameter int DEPTH = 40,
    parameter int AW    = 6
) (
    input  wire logic                i_clk,
    input  wire logic [AW-1:0]       i_raddr,
    output gpdht_pkg::t_pin_rec      o_rdata,
    input  wire logic                i_we,
    input  wire logic [AW-1:0]       i_waddr,
    input  wire gpdht_pkg::t_pin_rec i_wdata
);
    import gpdht_pkg::*;

    t_pin_rec r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/gpdht_scan.sv -----
// Reply bit scanner: walks the forty reply bits, one per cycle, to find the line level.
`default_nettype none
module gpdht_scan (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gpdht_pkg::t_scan_req i_req,
    output gpdht_pkg::t_scan_rsp o_rsp
);
    import gpdht_pkg::*;

    logic        r_act, n_act;
    logic [5:0]  r_idx, n_idx;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_el;
    logic [39:0] r_bits;
    logic        r_done, n_done;
    logic        r_lvl, n_lvl;
    logic        r_fin, n_fin;
    logic        w_bit;
    logic [31:0] w_len;
    logic [31:0] w_off;

    assign w_bit = r_bits[39];
    assign w_len = T_BIT_LOW + (w_bit ? T_HIGH_ONE : T_HIGH_ZERO);
    assign w_off = r_el - r_pos;

    // One bit slot is checked each cycle, then the final low.
    always_comb begin
        n_act  = r_act;
        n_idx  = r_idx;
        n_pos  = r_pos;
        n_done = 1'b0;
        n_lvl  = r_lvl;
        n_fin  = r_fin;
        if (i_req.start) begin
            n_act = 1'b1;
            n_idx = 6'd0;
            n_pos = T_PRE_HIGH2;
        end else if (r_act) begin
            if (r_idx == 6'(REPLY_BITS)) begin
                n_act  = 1'b0;
                n_done = 1'b1;
                n_lvl  = !(r_el >= r_pos && w_off < T_BIT_LOW);
                n_fin  = n_lvl;
            end else if (r_el >= r_pos && w_off < w_len) begin
                n_act  = 1'b0;
                n_done = 1'b1;
                n_lvl  = (w_off >= T_BIT_LOW);
                n_fin  = 1'b0;
            end else begin
                n_idx = r_idx + 6'd1;
                n_pos = r_pos + w_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_act  <= n_act;
            r_done <= n_done;
        end
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_lvl <= n_lvl;
        r_fin <= n_fin;
        if (i_req.start) begin
            r_el   <= i_req.elapsed;
            r_bits <= i_req.bits;
        end else if (r_act) begin
            r_bits <= {r_bits[38:0], 1'b0};
        end
    end

    assign o_rsp = '{done: r_done, level: r_lvl, finished: r_fin};

endmodule
`default_nettype wire

// ----- rtl/core/gpio_pin_with_dht_responder.sv -----
// Top level of the GPIO pin bank with an emulated single-wire sensor responder.
//
// Usage: raise i_start for one cycle with the request fields while o_busy is low.
// The request is taken at that edge. Exactly one result follows, shown for one
// cycle with o_done high, carrying o_level and o_changed; the receiver cannot
// hold it off and must take it then.
// Timing: after acceptance the request passes the memory read, execute and done
// states, and the result is registered from the done state; a read of a replying
// sensor pin past its preamble also walks the reply bits in the single bit scanner,
// one per cycle, after the registered memory read. One request is processed at
// a time; o_busy falls in the result cycle, so the next request may be taken at the
// edge that ends it.
// Reset: synchronous active-low i_rst_n. After reset a clearing pass writes the
// reset record into every pin entry, one per cycle, with o_busy high. The threshold
// register may be written at any time via i_cfg_we and returns to 800 on reset.
`default_nettype none
module gpio_pin_with_dht_responder #(
    parameter int PIN_COUNT = 40
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_func,
    input  wire logic [5:0]  i_pin,
    input  wire logic [2:0]  i_arg,
    input  wire logic [31:0] i_now_us,
    input  wire logic signed [15:0] i_temperature,
    input  wire logic [15:0] i_humidity,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_done,
    output logic             o_level,
    output logic             o_changed
);
    import gpdht_pkg::*;

    localparam int AW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

    t_state      r_st, n_st;
    logic [15:0] r_min;
    logic        r_clr;
    logic [AW-1:0] r_clr_idx;
    logic [2:0]  r_func;
    logic [AW-1:0] r_pin;
    logic        r_valid;
    logic [2:0]  r_arg;
    logic [31:0] r_now;
    logic [15:0] r_temp, r_hum;
    t_pin_rec    w_rd, r_rec, n_rec;
    logic        r_lvl, n_lvl, r_chg, n_chg;
    logic        n_we;
    t_pin_rec    w_wdata;
    logic        w_we;
    logic [AW-1:0] w_waddr;
    t_scan_req   w_sreq;
    t_scan_rsp   w_srsp;
    logic [31:0] w_el;
    logic [15:0] w_tw;
    logic [7:0]  w_sum;
    logic        w_trig;
    logic [31:0] w_dur;
    logic        w_pin_ok;
    logic        n_done;

    assign w_pin_ok = ({26'd0, i_pin} < 32'(PIN_COUNT));

    gpdht_mem #(.DEPTH(PIN_COUNT), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_raddr(r_pin),
        .o_rdata(w_rd),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata)
    );

    gpdht_scan u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_sreq),
        .o_rsp  (w_srsp)
    );

    // Clearing pass or write-back of the modified record.
    always_comb begin
        if (r_clr) begin
            w_we    = 1'b1;
            w_waddr = r_clr_idx;
            w_wdata = '{level: LVL_UNKNOWN, mode: 3'd0, sens: 1'b0, busy: 1'b0,
                        temp: 16'd0, hum: 16'd0, low_start: 32'd0, trig: 32'd0};
        end else begin
            w_we    = n_we;
            w_waddr = r_pin;
            w_wdata = n_rec;
        end
    end

    // Reply word and checksum of the addressed sensor.
    assign w_el  = r_now - w_rd.trig;
    assign w_tw  = w_rd.temp[15] ? ((16'h0 - w_rd.temp) | 16'h8000) : w_rd.temp;
    assign w_sum = w_rd.hum[15:8] + w_rd.hum[7:0] + w_tw[15:8] + w_tw[7:0];
    assign w_dur = r_now - w_rd.low_start;
    assign w_trig = (w_dur > {16'd0, r_min});

    // Controller: next state, record update and result.
    always_comb begin
        n_st   = r_st;
        n_rec  = r_rec;
        n_lvl  = r_lvl;
        n_chg  = r_chg;
        n_we   = 1'b0;
        n_done = 1'b0;
        w_sreq = '{start: 1'b0, elapsed: w_el, bits: {w_rd.hum, w_tw, w_sum}};
        unique case (r_st)
            ST_IDLE: begin
                if (i_start && !r_clr) begin
                    n_st = ST_READ;
                end
            end
            ST_READ: begin
                n_st = ST_EXEC;
            end
            ST_EXEC: begin
                n_rec = w_rd;
                n_lvl = 1'b0;
                n_chg = 1'b0;
                n_st  = ST_DONE;
                if (r_valid) begin
                    case (r_func)
                        FUNC_MODE: begin
                            if (w_rd.sens && (r_arg == MODE_INPUT || r_arg == MODE_PULLUP)
                                && w_rd.mode == MODE_OUTPUT && w_rd.level == LVL_LOW
                                && w_trig) begin
                                n_rec.trig = r_now;
                                n_rec.busy = 1'b1;
                            end
                            n_rec.mode = r_arg;
                            if (w_rd.level == LVL_UNKNOWN) begin
                                if (r_arg == MODE_PULLUP) n_rec.level = LVL_HIGH;
                                else if (r_arg == MODE_PULLDOWN) n_rec.level = LVL_LOW;
                            end
                            n_we = 1'b1;
                        end
                        FUNC_WRITE: begin
                            if (w_rd.sens) begin
                                if (r_arg == 3'd0) begin
                                    if (w_rd.level != LVL_LOW) n_rec.low_start = r_now;
                                end else if (w_rd.level == LVL_LOW && w_trig) begin
                                    n_rec.trig = r_now;
                                    n_rec.busy = 1'b1;
                                end
                            end
                            n_rec.level = (r_arg != 3'd0) ? LVL_HIGH : LVL_LOW;
                            n_chg = (w_rd.level != n_rec.level);
                            n_we  = 1'b1;
                        end
                        FUNC_READ: begin
                            if (w_rd.sens) begin
                                if (!w_rd.busy) n_lvl = 1'b1;
                                else if (w_el < T_PRE_HIGH1) n_lvl = 1'b1;
                                else if (w_el < T_PRE_LOW) n_lvl = 1'b0;
                                else if (w_el < T_PRE_HIGH2) n_lvl = 1'b1;
                                else begin
                                    w_sreq.start = 1'b1;
                                    n_st = ST_SCAN;
                                end
                            end else if (w_rd.level == LVL_UNKNOWN) begin
                                n_lvl = (w_rd.mode == MODE_PULLUP);
                            end else begin
                                n_lvl = w_rd.level[0];
                            end
                        end
                        FUNC_DRIVE: begin
                            n_rec.level = (r_arg != 3'd0) ? LVL_HIGH : LVL_LOW;
                            n_we = 1'b1;
                        end
                        FUNC_LOAD: begin
                            n_rec.sens = 1'b1;
                            n_rec.temp = r_temp;
                            n_rec.hum  = r_hum;
                            n_we = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_srsp.done) begin
                    n_lvl = w_srsp.level;
                    if (w_srsp.finished) begin
                        n_rec.busy = 1'b0;
                        n_we = 1'b1;
                    end
                    n_st = ST_DONE;
                end
            end
            ST_DONE: begin
                n_done = 1'b1;
                n_st   = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // State, clearing pass, configuration and request capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_min     <= CFG_RESET;
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
            o_done    <= 1'b0;
        end else begin
            r_st   <= n_st;
            o_done <= n_done;
            if (i_cfg_we) r_min <= i_cfg_data;
            if (r_clr) begin
                if (r_clr_idx == AW'(PIN_COUNT - 1)) r_clr <= 1'b0;
                else r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
        r_rec <= n_rec;
        r_lvl <= n_lvl;
        r_chg <= n_chg;
        if (r_st == ST_IDLE && i_start && !r_clr) begin
            r_func  <= i_func;
            r_pin   <= i_pin[AW-1:0];
            r_valid <= w_pin_ok;
            r_arg   <= i_arg;
            r_now   <= i_now_us;
            r_temp  <= i_temperature;
            r_hum   <= i_humidity;
        end
    end

    assign o_busy    = (r_st != ST_IDLE) || r_clr;
    assign o_level   = o_done & r_lvl;
    assign o_changed = o_done & r_chg;

endmodule
`default_nettype wire

// ----- rtl/core/gpdht_chk.sv -----
// Port-level checker for the pin bank, bound to the top level.
`default_nettype none
module gpdht_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_done,
    input wire logic o_level,
    input wire logic o_changed
);
    // An accepted request makes the block busy.
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("not busy after request");
    // The block is free again in the result cycle.
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("busy during result");
    // Results last one cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result longer than one cycle");
    // Level and changed are never both set.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_level && o_changed)) else $error("level and changed together");
endmodule

bind gpio_pin_with_dht_responder gpdht_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_level  (o_level),
    .o_changed(o_changed)
);
`default_nettype wire

// ----- dv/gpdht_checker.sv -----
// Checker for the GPIO pin bank with sensor responder: predicts each result and compares it.
module gpdht_checker
    import gpdht_pkg::*;
#(
    parameter int PIN_COUNT = 40
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [2:0]  i_func,
    input  wire logic [5:0]  i_pin,
    input  wire logic [2:0]  i_arg,
    input  wire logic [31:0] i_now_us,
    input  wire logic [15:0] i_temperature,
    input  wire logic [15:0] i_humidity,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_done,
    input  wire logic        i_level,
    input  wire logic        i_changed,
    output int               o_pending,
    output int               o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic level;
        logic changed;
    } t_pin_result;

    // Shadow copy of the pin bank and the threshold register.
    logic [15:0] low_min_us;
    logic [1:0]  lvl_q   [PIN_COUNT];
    logic [2:0]  mode_q  [PIN_COUNT];
    logic        sens_q  [PIN_COUNT];
    logic [15:0] temp_q  [PIN_COUNT];
    logic [15:0] hum_q   [PIN_COUNT];
    logic        reply_q [PIN_COUNT];
    logic [31:0] lowt_q  [PIN_COUNT];
    logic [31:0] trig_q  [PIN_COUNT];

    t_pin_result pin_results_due[$];

    // Release of a host low pulse: a long enough pulse starts the reply.
    function automatic void release_line(int p, logic [31:0] now);
        if ((now - lowt_q[p]) > {16'd0, low_min_us}) begin
            trig_q[p]  = now;
            reply_q[p] = 1'b1;
        end
    endfunction

    // Line level of a replying sensor at a given time; clears the reply once it is over.
    function automatic logic reply_line_level(int p, logic [31:0] now);
        logic [31:0] el;
        logic [31:0] t0;
        logic [31:0] len;
        logic [15:0] tw;
        logic [7:0]  csum;
        logic [39:0] frame;
        el = now - trig_q[p];
        if (el < T_PRE_HIGH1) return 1'b1;
        if (el < T_PRE_LOW) return 1'b0;
        if (el < T_PRE_HIGH2) return 1'b1;
        // Sign-magnitude temperature word.
        tw = temp_q[p][15] ? ((-temp_q[p]) | 16'h8000) : temp_q[p];
        csum = hum_q[p][15:8] + hum_q[p][7:0] + tw[15:8] + tw[7:0];
        frame = {hum_q[p], tw, csum};
        t0 = T_PRE_HIGH2;
        for (int i = 0; i < REPLY_BITS; i++) begin
            len = T_BIT_LOW + (frame[REPLY_BITS-1-i] ? T_HIGH_ONE : T_HIGH_ZERO);
            if (el >= t0 && el < t0 + len) return (el - t0) >= T_BIT_LOW;
            t0 += len;
        end
        if (el < t0 + T_BIT_LOW) return 1'b0;
        reply_q[p] = 1'b0;
        return 1'b1;
    endfunction

    // Applies one request to the shadow bank and returns its result.
    function automatic t_pin_result apply_request(logic [2:0] f, logic [5:0] pn,
                                                  logic [2:0] a, logic [31:0] now,
                                                  logic [15:0] tc, logic [15:0] rh);
        t_pin_result r;
        logic [1:0]  nl;
        int          p;
        r = '0;
        p = pn;
        if (p >= PIN_COUNT) return r;
        case (f)
            FUNC_MODE: begin
                if (sens_q[p] && (a == MODE_INPUT || a == MODE_PULLUP) &&
                    mode_q[p] == MODE_OUTPUT && lvl_q[p] == LVL_LOW)
                    release_line(p, now);
                mode_q[p] = a;
                if (lvl_q[p] == LVL_UNKNOWN) begin
                    if (a == MODE_PULLUP) lvl_q[p] = LVL_HIGH;
                    else if (a == MODE_PULLDOWN) lvl_q[p] = LVL_LOW;
                end
            end
            FUNC_WRITE: begin
                nl = (a != 3'd0) ? LVL_HIGH : LVL_LOW;
                if (sens_q[p]) begin
                    if (nl == LVL_LOW) begin
                        if (lvl_q[p] != LVL_LOW) lowt_q[p] = now;
                    end else if (lvl_q[p] == LVL_LOW) begin
                        release_line(p, now);
                    end
                end
                if (lvl_q[p] != nl) begin
                    lvl_q[p]  = nl;
                    r.changed = 1'b1;
                end
            end
            FUNC_READ: begin
                if (sens_q[p]) r.level = reply_q[p] ? reply_line_level(p, now) : 1'b1;
                else if (lvl_q[p] == LVL_UNKNOWN) r.level = (mode_q[p] == MODE_PULLUP);
                else r.level = lvl_q[p][0];
            end
            FUNC_DRIVE: lvl_q[p] = (a != 3'd0) ? LVL_HIGH : LVL_LOW;
            FUNC_LOAD: begin
                sens_q[p] = 1'b1;
                temp_q[p] = tc;
                hum_q[p]  = rh;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Watch requests, configuration writes and results on every edge.
    always @(posedge i_clk) begin
        t_pin_result got;
        t_pin_result want;
        if (!i_rst_n) begin
            low_min_us = CFG_RESET;
            for (int i = 0; i < PIN_COUNT; i++) begin
                lvl_q[i]   = LVL_UNKNOWN;
                mode_q[i]  = 3'd0;
                sens_q[i]  = 1'b0;
                temp_q[i]  = '0;
                hum_q[i]   = '0;
                reply_q[i] = 1'b0;
                lowt_q[i]  = '0;
                trig_q[i]  = '0;
            end
            pin_results_due.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) low_min_us = i_cfg_data;
            if (i_done) begin
                got = '{level: i_level, changed: i_changed};
                if (pin_results_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%t: result level=%0b changed=%0b with no request pending",
                                 $realtime, i_level, i_changed);
                end else begin
                    want = pin_results_due.pop_front();
                    if (got != want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%t: expected level=%0b changed=%0b, got level=%0b changed=%0b",
                                     $realtime, want.level, want.changed, i_level, i_changed);
                    end
                end
            end
            if (i_start && !i_busy)
                pin_results_due.push_back(apply_request(i_func, i_pin, i_arg, i_now_us,
                                                        i_temperature, i_humidity));
        end
        o_pending <= pin_results_due.size();
    end

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

endmodule

// ----- dv/tb_gpio_pin_with_dht_responder.sv -----
// Testbench top for the GPIO pin bank with sensor responder: clock, reset, stimulus and verdict.
module tb_gpio_pin_with_dht_responder;
    import gpdht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PINS = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [2:0]  i_func = '0;
    logic [5:0]  i_pin = '0;
    logic [2:0]  i_arg = '0;
    logic [31:0] i_now_us = '0;
    logic signed [15:0] i_temperature = '0;
    logic [15:0] i_humidity = '0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_done;
    logic        o_level;
    logic        o_changed;
    int          pending;
    int          errors;

    int          idle_pct = 0;
    int          sent = 0;
    logic [15:0] threshold = CFG_RESET;

    always #10 i_clk = ~i_clk;

    gpio_pin_with_dht_responder #(.PIN_COUNT(PINS)) dut (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_func, .i_pin, .i_arg, .i_now_us,
        .i_temperature, .i_humidity, .i_cfg_we, .i_cfg_data, .o_done, .o_level,
        .o_changed
    );

    gpdht_checker #(.PIN_COUNT(PINS)) u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_func, .i_pin, .i_arg,
        .i_now_us, .i_temperature, .i_humidity, .i_cfg_we, .i_cfg_data,
        .i_done(o_done), .i_level(o_level), .i_changed(o_changed),
        .o_pending(pending), .o_errors(errors)
    );

    // Presents one request, sometimes after a random gap, and waits until it is taken.
    task automatic issue(input logic [2:0] f, input logic [5:0] p, input logic [2:0] a,
                         input logic [31:0] t, input logic [15:0] tc = '0,
                         input logic [15:0] rh = '0);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func        <= f;
        i_pin         <= p;
        i_arg         <= a;
        i_now_us      <= t;
        i_temperature <= tc;
        i_humidity    <= rh;
        i_start       <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sent++;
    endtask

    // Stops requesting until every outstanding result has come back.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || o_busy) @(posedge i_clk);
    endtask

    // Writes the pulse threshold while the block is idle.
    task automatic set_threshold(input logic [15:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        threshold  = v;
    endtask

    // One host exchange with a sensor: load, start pulse, release, then sample the reply.
    task automatic sensor_exchange(input logic [5:0] p, input logic [31:0] t0,
                                   input logic [31:0] hold);
        logic [31:0] rel;
        logic [31:0] el;
        int          reads;
        issue(FUNC_LOAD, p, 3'($urandom), $urandom, 16'($urandom), 16'($urandom));
        issue(FUNC_DRIVE, p, 3'd1, $urandom);
        issue(FUNC_MODE, p, MODE_OUTPUT, t0);
        issue(FUNC_WRITE, p, 3'd0, t0);
        rel = t0 + hold;
        case ($urandom_range(2))
            0: issue(FUNC_MODE, p, MODE_INPUT, rel);
            1: issue(FUNC_MODE, p, MODE_PULLUP, rel);
            default: issue(FUNC_WRITE, p, 3'($urandom_range(1, 7)), rel);
        endcase
        reads = $urandom_range(3, 8);
        el = 0;
        for (int k = 0; k < reads; k++) begin
            el += $urandom_range(0, 1300);
            issue(FUNC_READ, p, 3'($urandom), rel + el);
        end
        if ($urandom_range(1)) issue(FUNC_READ, p, 3'($urandom), rel + 32'd6000);
    endtask

    // Random phase: mostly well-formed exchanges, the rest arbitrary requests.
    task automatic random_phase(input int items);
        logic [31:0] hold;
        int          stop_at;
        stop_at = sent + items;
        while (sent < stop_at) begin
            if ($urandom_range(99) < 60) begin
                case ($urandom_range(5))
                    0: hold = {16'd0, threshold};
                    1: hold = {16'd0, threshold} + 1;
                    2: hold = $urandom_range(0, threshold);
                    default: hold = {16'd0, threshold} + $urandom_range(1, 400);
                endcase
                sensor_exchange(6'($urandom_range(PINS - 1)),
                                $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(300),
                                hold);
            end else begin
                issue(3'($urandom), $urandom_range(1) ? 6'($urandom_range(PINS - 1)) : 6'($urandom),
                      3'($urandom), $urandom, 16'($urandom), 16'($urandom));
            end
            if ($urandom_range(99) < 3) drain();
        end
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);

        // Directed: edge pins, unused codes, pull modes and a full reply across a time wrap.
        issue(FUNC_READ, 6'd63, 3'd7, 32'd0);
        issue(FUNC_WRITE, 6'd40, 3'd1, 32'd0);
        issue(3'd7, 6'd0, 3'd1, 32'd5);
        issue(FUNC_MODE, 6'd1, 3'd6, 32'd0);
        issue(FUNC_READ, 6'd1, 3'd0, 32'd0);
        issue(FUNC_MODE, 6'd2, MODE_PULLUP, 32'd0);
        issue(FUNC_READ, 6'd2, 3'd0, 32'd0);
        issue(FUNC_MODE, 6'd3, MODE_PULLDOWN, 32'd0);
        issue(FUNC_READ, 6'd3, 3'd0, 32'd0);
        issue(FUNC_READ, 6'd4, 3'd0, 32'd0);
        issue(FUNC_WRITE, 6'd5, 3'd1, 32'd0);
        issue(FUNC_WRITE, 6'd5, 3'd4, 32'd0);
        issue(FUNC_DRIVE, 6'd5, 3'd0, 32'd0);
        issue(FUNC_READ, 6'd5, 3'd0, 32'd0);
        issue(FUNC_LOAD, 6'd39, 3'd0, 32'd0, 16'h8000, 16'hFFFF);
        issue(FUNC_MODE, 6'd39, MODE_OUTPUT, 32'hFFFF_FF00);
        issue(FUNC_WRITE, 6'd39, 3'd0, 32'hFFFF_FF00);
        issue(FUNC_WRITE, 6'd39, 3'd1, 32'hFFFF_FF00 + 32'd801);
        issue(FUNC_READ, 6'd39, 3'd0, 32'hFFFF_FF00 + 32'd801 + 32'd39);
        issue(FUNC_READ, 6'd39, 3'd0, 32'hFFFF_FF00 + 32'd801 + 32'd119);
        issue(FUNC_READ, 6'd39, 3'd0, 32'hFFFF_FF00 + 32'd801 + 32'd199);
        issue(FUNC_READ, 6'd39, 3'd0, 32'hFFFF_FF00 + 32'd801 + 32'd250);
        issue(FUNC_READ, 6'd39, 3'd0, 32'hFFFF_FF00 + 32'd801 + 32'd6000);
        issue(FUNC_READ, 6'd39, 3'd0, 32'hFFFF_FF00 + 32'd801 + 32'd6001);
        issue(FUNC_LOAD, 6'd38, 3'd0, 32'd0, 16'h7FFF, 16'h0000);

        // Random phases under different thresholds and sender gaps.
        set_threshold(16'd0);
        idle_pct = 0;
        random_phase(150);
        set_threshold(16'hFFFF);
        idle_pct = 56;
        random_phase(150);
        set_threshold(16'($urandom_range(1, 2000)));
        idle_pct = 33;
        random_phase(150);
        set_threshold(CFG_RESET);
        idle_pct = 0;
        random_phase(150);

        drain();
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("gpio_pin_with_dht_responder: match");
        end else begin
            $display("gpio_pin_with_dht_responder: mismatch");
        end
        $finish;
    end

    // Guard against a hang.
    initial begin
        #50ms;
        $display("gpio_pin_with_dht_responder: mismatch");
        $finish;
    end

endmodule
